/* hdl/usb_control_request_handler_macros.svh */
// assertion macros for the usb control request handler
`ifndef USB_CONTROL_REQUEST_HANDLER_MACROS_SVH
`define USB_CONTROL_REQUEST_HANDLER_MACROS_SVH

// same-cycle implication
`define USBC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("usbc assertion failed");

// next-cycle implication
`define USBC_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("usbc assertion failed");

`endif

/* hdl/usbc_pkg.sv */
// shared types, codes and constants of the usb control request handler
package usbc_pkg;

  localparam int LEN_W   = 10;
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  // command codes
  localparam logic [1:0] CMD_SETUP     = 2'd0;
  localparam logic [1:0] CMD_BUS_RESET = 2'd1;
  localparam logic [1:0] CMD_SUSPEND   = 2'd2;
  localparam logic [1:0] CMD_WAKEUP    = 2'd3;

  // bmRequestType kind
  localparam logic [7:0] RT_KIND_MASK = 8'h60;
  localparam logic [7:0] RT_STANDARD  = 8'h00;
  localparam logic [7:0] RT_CLASS     = 8'h20;

  // standard request codes
  localparam logic [7:0] RQ_GET_STATUS        = 8'h00;
  localparam logic [7:0] RQ_CLEAR_FEATURE     = 8'h01;
  localparam logic [7:0] RQ_SET_FEATURE       = 8'h03;
  localparam logic [7:0] RQ_SET_ADDRESS       = 8'h05;
  localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'h06;
  localparam logic [7:0] RQ_GET_CONFIGURATION = 8'h08;
  localparam logic [7:0] RQ_SET_CONFIGURATION = 8'h09;

  // hid class request codes
  localparam logic [7:0] HRQ_GET_REPORT   = 8'h01;
  localparam logic [7:0] HRQ_GET_IDLE     = 8'h02;
  localparam logic [7:0] HRQ_GET_PROTOCOL = 8'h03;
  localparam logic [7:0] HRQ_SET_REPORT   = 8'h09;
  localparam logic [7:0] HRQ_SET_IDLE     = 8'h0A;
  localparam logic [7:0] HRQ_SET_PROTOCOL = 8'h0B;

  // descriptor types
  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_STRING = 8'h03;
  localparam logic [7:0] DT_HID    = 8'h21;
  localparam logic [7:0] DT_REPORT = 8'h22;

  localparam logic [7:0]       STR_IDX_LANG    = 8'h00;
  localparam logic [7:0]       STR_IDX_MAKER   = 8'h01;
  localparam logic [7:0]       STR_IDX_PRODUCT = 8'h02;
  localparam logic [7:0]       STR_IDX_SERIAL  = 8'h03;
  localparam logic [7:0]       STR_IDX_CFGREQ  = 8'hEE;
  localparam logic [6:0]       EP_ADDR_MASK    = 7'h7F;
  localparam logic [LEN_W-1:0] HID_DESC_BYTES  = 10'd9;
  localparam logic [LEN_W-1:0] ONE_BYTE        = 10'd1;
  localparam logic [LEN_W-1:0] STATUS_BYTES    = 10'd2;
  localparam logic [7:0]       PROTOCOL_REPORT = 8'h01;

  // actions
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_SEND   = 2'd1;
  localparam logic [1:0] ACT_STATUS = 2'd2;
  localparam logic [1:0] ACT_STALL  = 2'd3;

  // data sources
  localparam logic [3:0] SRC_DEVICE  = 4'd0;
  localparam logic [3:0] SRC_CONFIG  = 4'd1;
  localparam logic [3:0] SRC_LANG    = 4'd2;
  localparam logic [3:0] SRC_MAKER   = 4'd3;
  localparam logic [3:0] SRC_PRODUCT = 4'd4;
  localparam logic [3:0] SRC_SERIAL  = 4'd5;
  localparam logic [3:0] SRC_HID     = 4'd6;
  localparam logic [3:0] SRC_REPORT  = 4'd7;
  localparam logic [3:0] SRC_INLINE  = 4'd8;
  localparam logic [3:0] SRC_STATUS  = 4'd9;
  localparam logic [3:0] SRC_EMPTY   = 4'd10;

  // device state codes as reported
  localparam logic [2:0] DSC_UNATTACHED = 3'd0;
  localparam logic [2:0] DSC_DEFAULT    = 3'd1;
  localparam logic [2:0] DSC_ADDRESSED  = 3'd2;
  localparam logic [2:0] DSC_CONFIGURED = 3'd3;
  localparam logic [2:0] DSC_SUSPENDED  = 3'd4;

  // event bits
  localparam int         EV_BIT_RESET = 0;
  localparam logic [4:0] EV_RESET     = 5'b00001;
  localparam logic [4:0] EV_SUSPEND   = 5'b00010;
  localparam logic [4:0] EV_RESUME    = 5'b00100;
  localparam logic [4:0] EV_ENUM      = 5'b01000;
  localparam logic [4:0] EV_CFGREQ    = 5'b10000;

  // configuration register indexes
  localparam logic [2:0] REG_DEVICE_DESC = 3'd0;
  localparam logic [2:0] REG_CONFIG_DESC = 3'd1;
  localparam logic [2:0] REG_REPORT_DESC = 3'd2;
  localparam logic [2:0] REG_LANG_STR    = 3'd3;
  localparam logic [2:0] REG_MAKER_STR   = 3'd4;
  localparam logic [2:0] REG_PRODUCT_STR = 3'd5;
  localparam logic [2:0] REG_SERIAL_STR  = 3'd6;

  typedef enum logic [4:0] {
    DS_UNATTACHED = 5'b00001,
    DS_DEFAULT    = 5'b00010,
    DS_ADDRESSED  = 5'b00100,
    DS_CONFIGURED = 5'b01000,
    DS_SUSPENDED  = 5'b10000
  } dev_st_t;

  typedef enum logic [3:0] {
    OP_BUS_RESET  = 4'd0,
    OP_SUSPEND    = 4'd1,
    OP_WAKEUP     = 4'd2,
    OP_SEND       = 4'd3,
    OP_SEND_CFGV  = 4'd4,
    OP_SEND_IDLE  = 4'd5,
    OP_SET_ADDR   = 4'd6,
    OP_SET_CONFIG = 4'd7,
    OP_SET_IDLE   = 4'd8,
    OP_ACK        = 4'd9,
    OP_STALL      = 4'd10
  } op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
  } req_t;

  typedef struct packed {
    logic [7:0]       device_desc;
    logic [LEN_W-1:0] config_desc;
    logic [LEN_W-1:0] report_desc;
    logic [7:0]       lang_str;
    logic [7:0]       maker_str;
    logic [7:0]       product_str;
    logic [7:0]       serial_str;
  } desc_len_t;

  typedef struct packed {
    op_t              op;
    logic [3:0]       src;
    logic [LEN_W-1:0] len;
    logic             zlp;
    logic [7:0]       inl;
    logic [7:0]       arg;
    logic [1:0]       halt;
    logic             cfgreq;
  } item_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [3:0]       data_source;
    logic [LEN_W-1:0] send_length;
    logic             needs_zero_packet;
    logic [7:0]       inline_byte;
    logic [2:0]       device_state;
    logic [6:0]       device_address;
    logic [1:0]       clear_halt_endpoint;
    logic [4:0]       event_mask;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2:0] dev_st_code(dev_st_t st);
    logic [2:0] c;
    unique case (st)
      DS_UNATTACHED: c = DSC_UNATTACHED;
      DS_DEFAULT:    c = DSC_DEFAULT;
      DS_ADDRESSED:  c = DSC_ADDRESSED;
      DS_CONFIGURED: c = DSC_CONFIGURED;
      DS_SUSPENDED:  c = DSC_SUSPENDED;
      default:       c = DSC_UNATTACHED;
    endcase
    return c;
  endfunction

endpackage

/* hdl/usbc_req_if.sv */
// request channel: setup packets and bus events
interface usbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_index;
  logic [15:0] request_length;

  modport source (output valid, command, request_type, request_code, request_value,
                  request_index, request_length, input ready);
  modport sink (input valid, command, request_type, request_code, request_value,
                request_index, request_length, output ready);
endinterface

/* hdl/usbc_res_if.sv */
// result channel: one decision per request or event
interface usbc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [3:0] data_source;
  logic [9:0] send_length;
  logic       needs_zero_packet;
  logic [7:0] inline_byte;
  logic [2:0] device_state;
  logic [6:0] device_address;
  logic [1:0] clear_halt_endpoint;
  logic [4:0] event_mask;

  modport source (output valid, action, data_source, send_length, needs_zero_packet,
                  inline_byte, device_state, device_address, clear_halt_endpoint,
                  event_mask, input ready);
  modport sink (input valid, action, data_source, send_length, needs_zero_packet,
                inline_byte, device_state, device_address, clear_halt_endpoint,
                event_mask, output ready);
endinterface

/* hdl/usbc_cfg_if.sv */
// configuration write channel
interface usbc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/usbc_regs.sv */
// descriptor length registers written through the configuration channel
module usbc_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [2:0]           wr_index,
  input  logic [9:0]           wr_data,
  output usbc_pkg::desc_len_t  lens
);
  import usbc_pkg::*;

  desc_len_t lens_r, lens_nxt;

  always_comb begin
    lens_nxt = lens_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_DEVICE_DESC: lens_nxt.device_desc = wr_data[7:0];
        REG_CONFIG_DESC: lens_nxt.config_desc = wr_data;
        REG_REPORT_DESC: lens_nxt.report_desc = wr_data;
        REG_LANG_STR:    lens_nxt.lang_str    = wr_data[7:0];
        REG_MAKER_STR:   lens_nxt.maker_str   = wr_data[7:0];
        REG_PRODUCT_STR: lens_nxt.product_str = wr_data[7:0];
        REG_SERIAL_STR:  lens_nxt.serial_str  = wr_data[7:0];
        default:         lens_nxt = lens_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lens_r.device_desc <= 8'd18;
      lens_r.config_desc <= 10'd34;
      lens_r.report_desc <= 10'd63;
      lens_r.lang_str    <= 8'd4;
      lens_r.maker_str   <= 8'd0;
      lens_r.product_str <= 8'd0;
      lens_r.serial_str  <= 8'd0;
    end else begin
      lens_r <= lens_nxt;
    end
  end

  assign lens = lens_r;
endmodule

/* hdl/usbc_front.sv */
// front end: takes requests, decodes them and works out length and zero packet
module usbc_front #(
  parameter int PACKET_BYTES = 64,
  parameter int REPORT_BYTES = 8
) (
  input  logic                in_valid,
  output logic                in_ready,
  input  usbc_pkg::req_t      req,
  input  usbc_pkg::desc_len_t lens,
  input  usbc_pkg::q_stat_t   q_stat,
  output logic                push,
  output usbc_pkg::item_t     item
);
  import usbc_pkg::*;

  localparam int               LEN_MAX    = (1 << LEN_W) - 1;
  localparam int               MULT_COUNT = LEN_MAX / PACKET_BYTES;
  localparam logic [LEN_W-1:0] REPORT_LEN = LEN_W'(REPORT_BYTES);

  logic [7:0]       dtype;
  logic [7:0]       dindex;
  logic [6:0]       ep;
  logic             is_send;
  logic [LEN_W-1:0] sel_len;
  logic [LEN_W-1:0] n;
  logic             on_packet;
  item_t            it;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  assign dtype  = req.request_value[15:8];
  assign dindex = req.request_value[7:0];
  assign ep     = req.request_index[6:0] & EP_ADDR_MASK;

  always_comb begin
    it      = '0;
    it.op   = OP_STALL;
    is_send = 1'b0;
    sel_len = '0;
    unique case (req.command)
      CMD_BUS_RESET: it.op = OP_BUS_RESET;
      CMD_SUSPEND:   it.op = OP_SUSPEND;
      CMD_WAKEUP:    it.op = OP_WAKEUP;
      default: begin
        priority if ((req.request_type & RT_KIND_MASK) == RT_STANDARD) begin
          priority case (req.request_code)
            RQ_GET_DESCRIPTOR: begin
              priority case (dtype)
                DT_DEVICE: begin
                  it.op = OP_SEND; it.src = SRC_DEVICE; is_send = 1'b1;
                  sel_len = {2'b00, lens.device_desc};
                end
                DT_CONFIG: begin
                  it.op = OP_SEND; it.src = SRC_CONFIG; is_send = 1'b1;
                  sel_len = lens.config_desc; it.cfgreq = 1'b1;
                end
                DT_STRING: begin
                  it.cfgreq = (dindex == STR_IDX_CFGREQ);
                  priority case (dindex)
                    STR_IDX_LANG: begin
                      it.op = OP_SEND; it.src = SRC_LANG; is_send = 1'b1;
                      sel_len = {2'b00, lens.lang_str};
                    end
                    STR_IDX_MAKER: begin
                      it.op = OP_SEND; it.src = SRC_MAKER; is_send = 1'b1;
                      sel_len = {2'b00, lens.maker_str};
                    end
                    STR_IDX_PRODUCT: begin
                      it.op = OP_SEND; it.src = SRC_PRODUCT; is_send = 1'b1;
                      sel_len = {2'b00, lens.product_str};
                    end
                    STR_IDX_SERIAL: begin
                      it.op = OP_SEND; it.src = SRC_SERIAL; is_send = 1'b1;
                      sel_len = {2'b00, lens.serial_str};
                    end
                    default: it.op = OP_STALL;
                  endcase
                end
                DT_HID: begin
                  it.op = OP_SEND; it.src = SRC_HID; is_send = 1'b1;
                  sel_len = HID_DESC_BYTES;
                end
                DT_REPORT: begin
                  it.op = OP_SEND; it.src = SRC_REPORT; is_send = 1'b1;
                  sel_len = lens.report_desc;
                end
                default: it.op = OP_STALL;
              endcase
            end
            RQ_SET_ADDRESS: begin
              it.op  = OP_SET_ADDR;
              it.arg = dindex;
            end
            RQ_SET_CONFIGURATION: begin
              it.op  = OP_SET_CONFIG;
              it.arg = dindex;
            end
            RQ_GET_CONFIGURATION: begin
              it.op = OP_SEND_CFGV; it.src = SRC_INLINE; is_send = 1'b1;
              sel_len = ONE_BYTE;
            end
            RQ_GET_STATUS: begin
              it.op = OP_SEND; it.src = SRC_STATUS; is_send = 1'b1;
              sel_len = STATUS_BYTES;
            end
            RQ_CLEAR_FEATURE, RQ_SET_FEATURE: begin
              it.op = OP_ACK;
              // endpoint halt clear only for feature selector zero on endpoints 1 to 3
              if (req.request_code == RQ_CLEAR_FEATURE && req.request_value == 16'd0 &&
                  ep != 7'd0 && ep <= 7'd3) begin
                it.halt = ep[1:0];
              end
            end
            default: it.op = OP_STALL;
          endcase
        end else if ((req.request_type & RT_KIND_MASK) == RT_CLASS) begin
          priority case (req.request_code)
            HRQ_SET_IDLE: begin
              it.op  = OP_SET_IDLE;
              it.arg = dtype;
            end
            HRQ_GET_IDLE: begin
              it.op = OP_SEND_IDLE; it.src = SRC_INLINE; is_send = 1'b1;
              sel_len = ONE_BYTE;
            end
            HRQ_GET_PROTOCOL: begin
              it.op = OP_SEND; it.src = SRC_INLINE; is_send = 1'b1;
              sel_len = ONE_BYTE; it.inl = PROTOCOL_REPORT;
            end
            HRQ_SET_PROTOCOL, HRQ_SET_REPORT: it.op = OP_ACK;
            HRQ_GET_REPORT: begin
              it.op = OP_SEND; it.src = SRC_EMPTY; is_send = 1'b1;
              sel_len = REPORT_LEN; it.inl = dindex;
            end
            default: it.op = OP_STALL;
          endcase
        end else begin
          it.op = OP_STALL;
        end
      end
    endcase
  end

  // clamp to wLength
  always_comb begin
    if ({6'b000000, sel_len} > req.request_length) begin
      n = req.request_length[LEN_W-1:0];
    end else begin
      n = sel_len;
    end
  end

  // zero or a whole number of packets
  always_comb begin
    on_packet = 1'b0;
    for (int k = 0; k <= MULT_COUNT; k++) begin
      if (n == LEN_W'(k * PACKET_BYTES)) on_packet = 1'b1;
    end
  end

  always_comb begin
    item = it;
    if (is_send) begin
      item.len = n;
      item.zlp = on_packet && (req.request_length > {6'b000000, n});
    end
  end
endmodule

/* hdl/usbc_fifo.sv */
// short queue of decoded items between front and back
module usbc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  usbc_pkg::item_t   push_item,
  input  logic              pop,
  output usbc_pkg::item_t   head,
  output usbc_pkg::q_stat_t stat
);
  import usbc_pkg::*;

  item_t             slots [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr_r] <= push_item;
  end
endmodule

/* hdl/usbc_back.sv */
// back end: applies items to the device state and registers the result
module usbc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  usbc_pkg::item_t   head,
  input  usbc_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output usbc_pkg::res_t    res
);
  import usbc_pkg::*;

  dev_st_t    st_r, st_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic [7:0] cfgv_r, cfgv_nxt;
  logic [7:0] idle_r, idle_nxt;
  logic       out_valid_r;
  res_t       res_r, r;

  assign pop = !q_stat.empty && (!out_valid_r || out_ready);

  always_comb begin
    st_nxt   = st_r;
    addr_nxt = addr_r;
    cfgv_nxt = cfgv_r;
    idle_nxt = idle_r;
    r        = '0;
    r.action = ACT_NONE;
    unique case (head.op)
      OP_BUS_RESET: begin
        st_nxt       = DS_DEFAULT;
        addr_nxt     = '0;
        cfgv_nxt     = '0;
        r.event_mask = EV_RESET;
      end
      OP_SUSPEND: begin
        st_nxt       = DS_SUSPENDED;
        r.event_mask = EV_SUSPEND;
      end
      OP_WAKEUP: begin
        if (st_r == DS_SUSPENDED) st_nxt = (cfgv_r != 8'd0) ? DS_CONFIGURED : DS_DEFAULT;
        r.event_mask = EV_RESUME;
      end
      OP_SEND, OP_SEND_CFGV, OP_SEND_IDLE: begin
        r.action            = ACT_SEND;
        r.data_source       = head.src;
        r.send_length       = head.len;
        r.needs_zero_packet = head.zlp;
        if (head.op == OP_SEND_CFGV) begin
          r.inline_byte = cfgv_r;
        end else if (head.op == OP_SEND_IDLE) begin
          r.inline_byte = idle_r;
        end else begin
          r.inline_byte = head.inl;
        end
      end
      OP_SET_ADDR: begin
        addr_nxt = head.arg[6:0];
        st_nxt   = DS_ADDRESSED;
        r.action = ACT_STATUS;
      end
      OP_SET_CONFIG: begin
        cfgv_nxt = head.arg;
        if (head.arg != 8'd0) begin
          st_nxt       = DS_CONFIGURED;
          r.event_mask = EV_ENUM | EV_CFGREQ;
        end
        r.action = ACT_STATUS;
      end
      OP_SET_IDLE: begin
        idle_nxt = head.arg;
        r.action = ACT_STATUS;
      end
      OP_ACK: begin
        r.action              = ACT_STATUS;
        r.clear_halt_endpoint = head.halt;
      end
      default: r.action = ACT_STALL;
    endcase
    if (head.cfgreq) r.event_mask = r.event_mask | EV_CFGREQ;
    r.device_state   = dev_st_code(st_nxt);
    r.device_address = addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= DS_UNATTACHED;
      addr_r      <= '0;
      cfgv_r      <= '0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        st_r        <= st_nxt;
        addr_r      <= addr_nxt;
        cfgv_r      <= cfgv_nxt;
        idle_r      <= idle_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= r;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;
endmodule

/* hdl/usb_control_request_handler.sv */
// Control endpoint request handler for a HID device: decodes setup packets
// and bus events and decides the response of each.
//
// in_req carries one setup packet or bus event (reset, suspend, wakeup) per
// transfer; out_res returns exactly one decision per item, in order: action,
// data source, clamped length, zero packet flag, inline byte, the device
// state and address after the item, a halt clear and the event bits.
// cfg_wr writes the descriptor length registers; it is always ready.
// Path: decode and queue write at the input transfer, then the state update
// into the output register once that register is empty or being taken.
// Throughput: one item per cycle while out_res.ready stays high, set by the
// single output register stage.
// If out_res is stalled the queue absorbs two more items before in_req.ready
// drops; nothing is lost or reordered.
// Reset (rst_n low, synchronous) empties the queue, drops out_res.valid,
// puts the device unattached with address, configuration and idle rate zero
// and loads the default descriptor lengths.
module usb_control_request_handler #(
  parameter int PACKET_BYTES = 64,
  parameter int REPORT_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  usbc_req_if.sink   in_req,
  usbc_res_if.source out_res,
  usbc_cfg_if.sink   cfg_wr
);
  import usbc_pkg::*;

`include "usb_control_request_handler_macros.svh"

  req_t      req;
  desc_len_t lens;
  q_stat_t   q_stat;
  item_t     fe_item;
  item_t     q_head;
  res_t      res;
  logic      push;
  logic      pop;

  assign cfg_wr.ready = 1'b1;

  assign req.command        = in_req.command;
  assign req.request_type   = in_req.request_type;
  assign req.request_code   = in_req.request_code;
  assign req.request_value  = in_req.request_value;
  assign req.request_index  = in_req.request_index;
  assign req.request_length = in_req.request_length;

  usbc_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr.valid),
    .wr_index (cfg_wr.index),
    .wr_data  (cfg_wr.data),
    .lens     (lens)
  );

  usbc_front #(
    .PACKET_BYTES (PACKET_BYTES),
    .REPORT_BYTES (REPORT_BYTES)
  ) u_front (
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .req      (req),
    .lens     (lens),
    .q_stat   (q_stat),
    .push     (push),
    .item     (fe_item)
  );

  usbc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (fe_item),
    .pop       (pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  usbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .res       (res)
  );

  assign out_res.action              = res.action;
  assign out_res.data_source         = res.data_source;
  assign out_res.send_length         = res.send_length;
  assign out_res.needs_zero_packet   = res.needs_zero_packet;
  assign out_res.inline_byte         = res.inline_byte;
  assign out_res.device_state        = res.device_state;
  assign out_res.device_address      = res.device_address;
  assign out_res.clear_halt_endpoint = res.clear_halt_endpoint;
  assign out_res.event_mask          = res.event_mask;

  `USBC_ASSERT_IMP(a_zlp_only_send, clk, rst_n, out_res.valid && out_res.needs_zero_packet, out_res.action == ACT_SEND)
  `USBC_ASSERT_IMP(a_reset_event_state, clk, rst_n, out_res.valid && out_res.event_mask[EV_BIT_RESET], out_res.device_state == DSC_DEFAULT && out_res.device_address == 7'd0)
  `USBC_ASSERT_IMP(a_quiet_fields, clk, rst_n, out_res.valid && out_res.action != ACT_SEND, out_res.send_length == 10'd0 && out_res.inline_byte == 8'd0)
  `USBC_ASSERT_NXT(a_pop_gives_valid, clk, rst_n, pop, out_res.valid)

endmodule

/* dv/usb_control_request_handler_tb.sv */
// self-checking testbench for the usb control request handler
module usb_control_request_handler_tb;
  import usbc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int PACKET_BYTES = 64;
  localparam int REPORT_BYTES = 8;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 185;

  // bmRequestType values used by the directed part
  localparam logic [7:0] STD_IN        = 8'h80;
  localparam logic [7:0] STD_OUT       = 8'h00;
  localparam logic [7:0] STD_EP_OUT    = 8'h02;
  localparam logic [7:0] CLS_IN        = 8'hA1;
  localparam logic [7:0] CLS_OUT       = 8'h21;
  localparam logic [7:0] VENDOR_TYPE   = 8'hC0;
  localparam logic [7:0] RESERVED_TYPE = 8'h60;

  class response_scoreboard;
    desc_len_t  lengths;
    logic [2:0] dev_state;
    logic [6:0] dev_address;
    logic [7:0] config_value;
    logic [7:0] idle_rate;
    res_t       expected_responses[$];
    int         mismatches;
    int         requests;
    int         action_count[4];

    function new();
      lengths.device_desc = 8'd18;
      lengths.config_desc = 10'd34;
      lengths.report_desc = 10'd63;
      lengths.lang_str    = 8'd4;
      lengths.maker_str   = 8'd0;
      lengths.product_str = 8'd0;
      lengths.serial_str  = 8'd0;
      dev_state    = DSC_UNATTACHED;
      dev_address  = '0;
      config_value = '0;
      idle_rate    = '0;
      mismatches   = 0;
      requests     = 0;
    endfunction

    function void set_length(logic [2:0] idx, logic [9:0] v);
      case (idx)
        REG_DEVICE_DESC: lengths.device_desc = v[7:0];
        REG_CONFIG_DESC: lengths.config_desc = v;
        REG_REPORT_DESC: lengths.report_desc = v;
        REG_LANG_STR:    lengths.lang_str    = v[7:0];
        REG_MAKER_STR:   lengths.maker_str   = v[7:0];
        REG_PRODUCT_STR: lengths.product_str = v[7:0];
        REG_SERIAL_STR:  lengths.serial_str  = v[7:0];
        default: ;
      endcase
    endfunction

    // data stage: clamp to wLength, trailing zero packet on short exact-fit transfers
    function res_t data_stage(logic [3:0] src, logic [9:0] len, logic [15:0] wlen,
                              logic [7:0] inl);
      res_t       d;
      logic [15:0] n;
      d = '0;
      n = ({6'd0, len} < wlen) ? {6'd0, len} : wlen;
      d.action            = ACT_SEND;
      d.data_source       = src;
      d.send_length       = n[9:0];
      d.needs_zero_packet = ((n == 0) || (n % PACKET_BYTES == 0)) && (wlen > n);
      d.inline_byte       = inl;
      return d;
    endfunction

    function res_t predict_response(req_t r);
      res_t        e;
      logic [4:0]  ev;
      logic [1:0]  halt;
      logic [7:0]  dtype;
      logic [7:0]  dindex;
      logic [6:0]  ep;
      logic [15:0] wlen;
      logic [15:0] rep_len;
      e    = '0;
      ev   = '0;
      halt = '0;
      wlen = r.request_length;
      dtype  = r.request_value[15:8];
      dindex = r.request_value[7:0];
      if (r.command == CMD_BUS_RESET) begin
        dev_state    = DSC_DEFAULT;
        dev_address  = '0;
        config_value = '0;
        ev           = EV_RESET;
      end else if (r.command == CMD_SUSPEND) begin
        dev_state = DSC_SUSPENDED;
        ev        = EV_SUSPEND;
      end else if (r.command == CMD_WAKEUP) begin
        if (dev_state == DSC_SUSPENDED)
          dev_state = (config_value != 0) ? DSC_CONFIGURED : DSC_DEFAULT;
        ev = EV_RESUME;
      end else if ((r.request_type & RT_KIND_MASK) == RT_STANDARD) begin
        case (r.request_code)
          RQ_GET_DESCRIPTOR: begin
            case (dtype)
              DT_DEVICE: e = data_stage(SRC_DEVICE, {2'b0, lengths.device_desc}, wlen, '0);
              DT_CONFIG: begin
                ev |= EV_CFGREQ;
                e = data_stage(SRC_CONFIG, lengths.config_desc, wlen, '0);
              end
              DT_STRING: begin
                if (dindex == STR_IDX_CFGREQ) ev |= EV_CFGREQ;
                case (dindex)
                  STR_IDX_LANG:
                    e = data_stage(SRC_LANG, {2'b0, lengths.lang_str}, wlen, '0);
                  STR_IDX_MAKER:
                    e = data_stage(SRC_MAKER, {2'b0, lengths.maker_str}, wlen, '0);
                  STR_IDX_PRODUCT:
                    e = data_stage(SRC_PRODUCT, {2'b0, lengths.product_str}, wlen, '0);
                  STR_IDX_SERIAL:
                    e = data_stage(SRC_SERIAL, {2'b0, lengths.serial_str}, wlen, '0);
                  default: e.action = ACT_STALL;
                endcase
              end
              DT_HID:    e = data_stage(SRC_HID, HID_DESC_BYTES, wlen, '0);
              DT_REPORT: e = data_stage(SRC_REPORT, lengths.report_desc, wlen, '0);
              default:   e.action = ACT_STALL;
            endcase
          end
          RQ_SET_ADDRESS: begin
            dev_address = r.request_value[6:0];
            dev_state   = DSC_ADDRESSED;
            e.action    = ACT_STATUS;
          end
          RQ_SET_CONFIGURATION: begin
            config_value = r.request_value[7:0];
            if (config_value != 0) begin
              dev_state = DSC_CONFIGURED;
              ev |= EV_ENUM | EV_CFGREQ;
            end
            e.action = ACT_STATUS;
          end
          RQ_GET_CONFIGURATION: e = data_stage(SRC_INLINE, ONE_BYTE, wlen, config_value);
          RQ_GET_STATUS:        e = data_stage(SRC_STATUS, STATUS_BYTES, wlen, '0);
          RQ_CLEAR_FEATURE, RQ_SET_FEATURE: begin
            // only an endpoint halt clear on endpoints one to three is reported
            if (r.request_code == RQ_CLEAR_FEATURE && r.request_value == 0) begin
              ep = r.request_index[6:0] & EP_ADDR_MASK;
              if (ep >= 1 && ep <= 3) halt = ep[1:0];
            end
            e.action = ACT_STATUS;
          end
          default: e.action = ACT_STALL;
        endcase
      end else if ((r.request_type & RT_KIND_MASK) == RT_CLASS) begin
        case (r.request_code)
          HRQ_SET_IDLE: begin
            idle_rate = r.request_value[15:8];
            e.action  = ACT_STATUS;
          end
          HRQ_GET_IDLE:     e = data_stage(SRC_INLINE, ONE_BYTE, wlen, idle_rate);
          HRQ_GET_PROTOCOL: e = data_stage(SRC_INLINE, ONE_BYTE, wlen, PROTOCOL_REPORT);
          HRQ_SET_PROTOCOL, HRQ_SET_REPORT: e.action = ACT_STATUS;
          HRQ_GET_REPORT: begin
            rep_len = (wlen < REPORT_BYTES) ? wlen : 16'(REPORT_BYTES);
            e = data_stage(SRC_EMPTY, rep_len[9:0], wlen, r.request_value[7:0]);
          end
          default: e.action = ACT_STALL;
        endcase
      end else begin
        e.action = ACT_STALL;
      end
      e.device_state        = dev_state;
      e.device_address      = dev_address;
      e.clear_halt_endpoint = halt;
      e.event_mask          = ev;
      return e;
    endfunction

    function void note_request(req_t r);
      res_t e;
      e = predict_response(r);
      expected_responses.push_back(e);
      action_count[e.action]++;
      requests++;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(res_t got);
      res_t want;
      if (expected_responses.size() == 0) begin
        $error("response with none expected: action %0d", got.action);
        mismatches++;
        return;
      end
      want = expected_responses.pop_front();
      compare_field("action", want.action, got.action);
      compare_field("data_source", want.data_source, got.data_source);
      compare_field("send_length", want.send_length, got.send_length);
      compare_field("needs_zero_packet", want.needs_zero_packet, got.needs_zero_packet);
      compare_field("inline_byte", want.inline_byte, got.inline_byte);
      compare_field("device_state", want.device_state, got.device_state);
      compare_field("device_address", want.device_address, got.device_address);
      compare_field("clear_halt_endpoint", want.clear_halt_endpoint, got.clear_halt_endpoint);
      compare_field("event_mask", want.event_mask, got.event_mask);
    endfunction

    function int outstanding();
      return expected_responses.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   send_gap_pct = 0;
  int   stall_pct = 0;
  int   settings_used = 0;
  response_scoreboard board = new();

  usbc_req_if in_req();
  usbc_res_if out_res();
  usbc_cfg_if cfg_wr();

  usb_control_request_handler #(
    .PACKET_BYTES(PACKET_BYTES),
    .REPORT_BYTES(REPORT_BYTES)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    out_res.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_res.valid && out_res.ready) begin
      got.action              = out_res.action;
      got.data_source         = out_res.data_source;
      got.send_length         = out_res.send_length;
      got.needs_zero_packet   = out_res.needs_zero_packet;
      got.inline_byte         = out_res.inline_byte;
      got.device_state        = out_res.device_state;
      got.device_address      = out_res.device_address;
      got.clear_halt_endpoint = out_res.clear_halt_endpoint;
      got.event_mask          = out_res.event_mask;
      board.check_response(got);
    end
  end

  // ends the run when no transfer happens on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready) ||
          (cfg_wr.valid && cfg_wr.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_request(input req_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid          <= 1'b1;
    in_req.command        <= r.command;
    in_req.request_type   <= r.request_type;
    in_req.request_code   <= r.request_code;
    in_req.request_value  <= r.request_value;
    in_req.request_index  <= r.request_index;
    in_req.request_length <= r.request_length;
    do @(posedge clk); while (!in_req.ready);
    board.note_request(r);
  endtask

  task automatic drain_responses();
    in_req.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_lengths(input logic [9:0] vals [7]);
    for (int i = 0; i < 7; i++) begin
      cfg_wr.valid <= 1'b1;
      cfg_wr.index <= 3'(i);
      cfg_wr.data  <= vals[i];
      do @(posedge clk); while (!cfg_wr.ready);
      board.set_length(3'(i), vals[i]);
    end
    cfg_wr.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic req_t setup_req(logic [7:0] rtype, logic [7:0] code, logic [15:0] val,
                                     logic [15:0] idx, logic [15:0] wlen);
    req_t r;
    r.command        = CMD_SETUP;
    r.request_type   = rtype;
    r.request_code   = code;
    r.request_value  = val;
    r.request_index  = idx;
    r.request_length = wlen;
    return r;
  endfunction

  function automatic req_t bus_event(logic [1:0] cmd);
    req_t r;
    r = setup_req(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    r.command = cmd;
    return r;
  endfunction

  // lengths around clamp points, packet multiples and the full range
  function automatic logic [15:0] random_wlength();
    case ($urandom_range(6))
      0:       return 16'($urandom_range(1));
      1:       return 16'($urandom_range(2, 20));
      2:       return 16'(PACKET_BYTES * $urandom_range(1, 16));
      3:       return 16'($urandom_range(40, 300));
      4:       return 16'($urandom_range(900, 1100));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.command        = 2'($urandom);
    r.request_type   = 8'($urandom);
    r.request_code   = 8'($urandom);
    r.request_value  = 16'($urandom);
    r.request_index  = 16'($urandom);
    r.request_length = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 6) return r;
    r.request_length = random_wlength();
    if (pick < 14) begin
      r.command = 2'($urandom_range(CMD_BUS_RESET, CMD_WAKEUP));
      return r;
    end
    r.command = CMD_SETUP;
    r.request_type &= ~RT_KIND_MASK;
    if (pick < 60) begin
      r.request_type |= RT_STANDARD;
      case ($urandom_range(11))
        0, 1, 2, 3, 11: begin
          r.request_code = RQ_GET_DESCRIPTOR;
          case ($urandom_range(7))
            0:       r.request_value[15:8] = DT_DEVICE;
            1:       r.request_value[15:8] = DT_CONFIG;
            2, 3, 4: r.request_value[15:8] = DT_STRING;
            5:       r.request_value[15:8] = DT_HID;
            6:       r.request_value[15:8] = DT_REPORT;
            default: ;
          endcase
          if (r.request_value[15:8] == DT_STRING && $urandom_range(9) < 8) begin
            if ($urandom_range(5) == 0)
              r.request_value[7:0] = STR_IDX_CFGREQ;
            else
              r.request_value[7:0] = 8'($urandom_range(STR_IDX_LANG, STR_IDX_SERIAL));
          end
        end
        4: r.request_code = RQ_SET_ADDRESS;
        5: begin
          r.request_code = RQ_SET_CONFIGURATION;
          if ($urandom_range(3) == 0) r.request_value[7:0] = '0;
        end
        6: r.request_code = RQ_GET_CONFIGURATION;
        7: r.request_code = RQ_GET_STATUS;
        8: begin
          r.request_code = RQ_CLEAR_FEATURE;
          if ($urandom_range(4) != 0) r.request_value = '0;
          r.request_index[6:0] = 7'($urandom_range(4));
        end
        9: r.request_code = RQ_SET_FEATURE;
        default: ;
      endcase
    end else if (pick < 94) begin
      r.request_type |= RT_CLASS;
      case ($urandom_range(7))
        0:    r.request_code = HRQ_SET_IDLE;
        1:    r.request_code = HRQ_GET_IDLE;
        2:    r.request_code = HRQ_GET_PROTOCOL;
        3:    r.request_code = HRQ_SET_REPORT;
        4:    r.request_code = HRQ_SET_PROTOCOL;
        5, 6: r.request_code = HRQ_GET_REPORT;
        default: ;
      endcase
    end else begin
      // vendor or reserved kinds
      r.request_type |= ($urandom_range(1) != 0) ? VENDOR_TYPE & RT_KIND_MASK : RESERVED_TYPE;
    end
    return r;
  endfunction

  task automatic run_directed();
    send_request(setup_req(STD_IN, RQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, '0, 16'd64));
    send_request(bus_event(CMD_BUS_RESET));
    send_request(setup_req(STD_IN, RQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, '0, 16'd0));
    send_request(setup_req(STD_IN, RQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, '0, 16'hFFFF));
    send_request(setup_req(STD_OUT, RQ_SET_ADDRESS, 16'hFFFF, '0, '0));
    send_request(setup_req(STD_IN, RQ_GET_DESCRIPTOR, {DT_STRING, STR_IDX_LANG}, '0, 16'd2));
    send_request(setup_req(STD_IN, RQ_GET_DESCRIPTOR, {DT_STRING, STR_IDX_MAKER}, '0, 16'd255));
    send_request(setup_req(STD_IN, RQ_GET_DESCRIPTOR, {DT_STRING, STR_IDX_SERIAL}, '0, 16'd1));
    send_request(setup_req(STD_IN, RQ_GET_DESCRIPTOR, {DT_STRING, STR_IDX_CFGREQ}, '0, 16'd64));
    send_request(setup_req(STD_IN, RQ_GET_DESCRIPTOR, {DT_STRING, 8'h04}, '0, 16'd64));
    send_request(setup_req(STD_IN, RQ_GET_DESCRIPTOR, {DT_HID, 8'h00}, '0, 16'd9));
    send_request(setup_req(STD_IN, RQ_GET_DESCRIPTOR, {DT_REPORT, 8'h00}, '0, 16'hFFFF));
    send_request(setup_req(STD_IN, RQ_GET_DESCRIPTOR, 16'h0700, '0, 16'd64));
    send_request(setup_req(STD_OUT, RQ_SET_CONFIGURATION, 16'h0001, '0, '0));
    send_request(setup_req(STD_IN, RQ_GET_CONFIGURATION, '0, '0, 16'd1));
    send_request(setup_req(STD_IN, RQ_GET_STATUS, '0, '0, 16'd2));
    send_request(setup_req(STD_EP_OUT, RQ_CLEAR_FEATURE, '0, 16'hFF83, '0));
    send_request(setup_req(STD_EP_OUT, RQ_CLEAR_FEATURE, 16'h0001, 16'h0002, '0));
    send_request(setup_req(STD_EP_OUT, RQ_SET_FEATURE, '0, 16'h0081, '0));
    send_request(setup_req(CLS_OUT, HRQ_SET_IDLE, 16'h7F00, '0, '0));
    send_request(setup_req(CLS_IN, HRQ_GET_IDLE, '0, '0, 16'd1));
    send_request(setup_req(CLS_IN, HRQ_GET_PROTOCOL, '0, '0, 16'd1));
    send_request(setup_req(CLS_OUT, HRQ_SET_REPORT, 16'h0200, '0, 16'd1));
    send_request(setup_req(CLS_OUT, HRQ_SET_PROTOCOL, '0, '0, '0));
    send_request(setup_req(CLS_IN, HRQ_GET_REPORT, 16'h01AB, '0, 16'd3));
    send_request(setup_req(CLS_IN, HRQ_GET_REPORT, 16'h0100, '0, 16'hFFFF));
    send_request(setup_req(CLS_IN, 8'hFF, '0, '0, 16'd8));
    send_request(setup_req(VENDOR_TYPE, RQ_GET_STATUS, '0, '0, 16'd2));
    send_request(setup_req(RESERVED_TYPE, RQ_GET_STATUS, '0, '0, 16'd2));
    send_request(setup_req(STD_IN, 8'h0C, '0, '0, 16'd2));
    // suspend and resume with and without a configuration
    send_request(bus_event(CMD_SUSPEND));
    send_request(bus_event(CMD_WAKEUP));
    send_request(setup_req(STD_OUT, RQ_SET_CONFIGURATION, 16'hFF00, '0, '0));
    send_request(bus_event(CMD_SUSPEND));
    send_request(bus_event(CMD_WAKEUP));
    send_request(bus_event(CMD_WAKEUP));
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      // hold off once per phase until the block has answered everything
      if (i == count / 2) drain_responses();
      send_request(random_request());
    end
  endtask

  initial begin
    logic [9:0] lens [7];
    rst_n                 = 1'b0;
    in_req.valid          = 1'b0;
    in_req.command        = CMD_SETUP;
    in_req.request_type   = '0;
    in_req.request_code   = '0;
    in_req.request_value  = '0;
    in_req.request_index  = '0;
    in_req.request_length = '0;
    cfg_wr.valid          = 1'b0;
    cfg_wr.index          = REG_DEVICE_DESC;
    cfg_wr.data           = '0;
    out_res.ready         = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (int phase = 0; phase < 5; phase++) begin
      drain_responses();
      case (phase)
        0: lens = '{10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF};
        1: lens = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0};
        2: lens = '{10'd64, 10'd128, 10'd640, 10'd64, 10'd192, 10'd128, 10'd0};
        default: begin
          for (int i = 0; i < 7; i++) lens[i] = 10'($urandom);
        end
      endcase
      write_lengths(lens);
      case (phase)
        1:       begin send_gap_pct = 58; stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  stall_pct = 58; end
        3:       begin send_gap_pct = 34; stall_pct = 34; end
        default: begin send_gap_pct = 0;  stall_pct = 0;  end
      endcase
      run_random(PHASE_ITEMS);
    end

    drain_responses();
    repeat (6) @(posedge clk);

    $display("run covered %0d requests and bus events under %0d length settings",
             board.requests, settings_used);
    $display("responses: %0d data stages, %0d status acks, %0d stalls, %0d mismatches",
             board.action_count[ACT_SEND], board.action_count[ACT_STATUS],
             board.action_count[ACT_STALL], board.mismatches);
    if (board.mismatches == 0 && board.outstanding() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
